[design/fectpe_pkg.sv]
// ----------------------------------------------------------------------------
// fectpe_pkg
// Shared types and constants of the trainer page engine: page numbers,
// register indexes, reset values and the packed layout of both channels.
// ----------------------------------------------------------------------------
package fectpe_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 136;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BG_INTERVAL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STALE_TMO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SERIAL      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HW_REV      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MANUF_ID    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MODEL       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SW_REV      = 3'd6;

    localparam logic [7:0]  RST_BG_INTERVAL = 8'd64;
    localparam logic [15:0] RST_STALE_TMO   = 16'd3000;
    localparam logic [31:0] RST_SERIAL      = 32'd0;
    localparam logic [7:0]  RST_HW_REV      = 8'd1;
    localparam logic [15:0] RST_MANUF_ID    = 16'd255;
    localparam logic [15:0] RST_MODEL       = 16'd1;
    localparam logic [7:0]  RST_SW_REV      = 8'd1;

    // page numbers
    localparam logic [7:0] PAGE_GENERAL = 8'h10;
    localparam logic [7:0] PAGE_TRAINER = 8'h19;
    localparam logic [7:0] PAGE_CAPS    = 8'h36;
    localparam logic [7:0] PAGE_STATUS  = 8'h47;
    localparam logic [7:0] PAGE_MANUF   = 8'h50;
    localparam logic [7:0] PAGE_PRODUCT = 8'h51;
    localparam logic [7:0] PAGE_RESIST  = 8'h30;
    localparam logic [7:0] PAGE_POWER   = 8'h31;
    localparam logic [7:0] PAGE_TRACK   = 8'h33;

    localparam logic [7:0] EQUIP_TRAINER = 8'h19;
    localparam logic [7:0] CAPS_ALL      = 8'h07;
    localparam logic [7:0] BYTE_NA       = 8'hFF;

    localparam logic [3:0] FE_READY  = 4'd2;
    localparam logic [3:0] FE_IN_USE = 4'd3;

    localparam logic [11:0] POWER_MAX     = 12'd4094;
    localparam logic [11:0] POWER_INVALID = 12'hFFF;

    // command status codes
    localparam logic [1:0] CMD_PASS          = 2'd0;
    localparam logic [1:0] CMD_NOT_SUPPORTED = 2'd2;

    // control modes
    localparam logic [1:0] MODE_POWER  = 2'd0;
    localparam logic [1:0] MODE_RESIST = 2'd1;
    localparam logic [1:0] MODE_SIM    = 2'd2;

    // transaction kinds
    localparam logic KIND_SLOT = 1'b0;
    localparam logic KIND_RX   = 1'b1;

    // background rotation
    localparam logic [1:0] BG_CAPS  = 2'd0;
    localparam logic [1:0] BG_MANUF = 2'd1;
    localparam logic [1:0] BG_LAST  = 2'd2;

    // floor(x / 250) = ((x >> 1) * RECIP_125) >> RECIP_SHIFT for 32-bit x
    localparam logic [31:0] RECIP_125   = 32'd2199023256;
    localparam int          RECIP_SHIFT = 38;

    typedef struct packed {
        logic [7:0]  bg_interval;
        logic [15:0] stale_timeout_ms;
        logic [31:0] device_serial;
        logic [7:0]  hw_revision;
        logic [15:0] manufacturer_id;
        logic [15:0] model_number;
        logic [7:0]  sw_revision;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] rx_payload;
        logic [15:0] power_watts;
        logic [7:0]  cadence_rpm;
        logic        data_valid;
        logic [31:0] data_age_ms;
        logic [31:0] elapsed_ms;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [63:0] payload;
        logic [1:0]  control_mode;
        logic [13:0] target_power_w;
        logic [6:0]  resistance_pct;
        logic [15:0] wind_speed;
        logic [15:0] grade;
        logic [7:0]  rolling_coeff;
        logic [7:0]  wind_coeff;
    } res_item_t;

endpackage

[design/fectpe_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fectpe_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module fectpe_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [fectpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fectpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fectpe_pkg::cfg_t                   cfg
);
    import fectpe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_BG_INTERVAL: cfg_next.bg_interval      = cfg_wdata[7:0];
                REG_STALE_TMO:   cfg_next.stale_timeout_ms = cfg_wdata[15:0];
                REG_SERIAL:      cfg_next.device_serial    = cfg_wdata[31:0];
                REG_HW_REV:      cfg_next.hw_revision      = cfg_wdata[7:0];
                REG_MANUF_ID:    cfg_next.manufacturer_id  = cfg_wdata[15:0];
                REG_MODEL:       cfg_next.model_number     = cfg_wdata[15:0];
                REG_SW_REV:      cfg_next.sw_revision      = cfg_wdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bg_interval      <= RST_BG_INTERVAL;
            cfg_reg.stale_timeout_ms <= RST_STALE_TMO;
            cfg_reg.device_serial    <= RST_SERIAL;
            cfg_reg.hw_revision      <= RST_HW_REV;
            cfg_reg.manufacturer_id  <= RST_MANUF_ID;
            cfg_reg.model_number     <= RST_MODEL;
            cfg_reg.sw_revision      <= RST_SW_REV;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/fectpe_core.sv]
// ----------------------------------------------------------------------------
// fectpe_core
// Page selection, page building, control page decoding and the engine
// state (message counters, accumulated power, pending command status).
// ----------------------------------------------------------------------------
module fectpe_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fectpe_pkg::cfg_t      cfg,
    input  fectpe_pkg::in_item_t  item,
    input  logic                  advance,
    output logic                  has_result,
    output fectpe_pkg::res_item_t result
);
    import fectpe_pkg::*;

    logic [7:0]  icnt_reg, icnt_next;
    logic        parity_reg, parity_next;
    logic [7:0]  event_reg, event_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  bg_idx_reg, bg_idx_next;
    logic        pending_reg, pending_next;
    logic [7:0]  cmd_page_reg, cmd_page_next;
    logic [1:0]  cmd_status_reg, cmd_status_next;
    logic [31:0] cmd_data_reg, cmd_data_next;

    logic        stale;
    logic [3:0]  fe_state;
    logic [7:0]  icnt_inc;
    logic        bg_slot;
    logic [62:0] el_prod;
    logic [7:0]  el_byte;
    logic [11:0] pw_clamped;
    logic [11:0] inst_pw;
    logic [7:0]  cad_out;
    logic [15:0] acc_sum;
    logic [7:0]  event_inc;
    logic [7:0]  rx_page;

    assign stale    = !item.data_valid || (item.data_age_ms > {16'd0, cfg.stale_timeout_ms});
    assign fe_state = stale ? FE_READY : FE_IN_USE;
    assign icnt_inc = icnt_reg + 8'd1;
    assign bg_slot  = icnt_inc >= cfg.bg_interval;
    assign el_prod  = 63'(item.elapsed_ms[31:1]) * 63'(RECIP_125);
    assign el_byte  = el_prod[RECIP_SHIFT +: 8];
    assign event_inc = event_reg + 8'd1;
    assign rx_page  = item.rx_payload[7:0];

    always_comb begin
        if (item.power_watts[15]) begin
            pw_clamped = 12'd0;
        end else if (item.power_watts > {4'd0, POWER_MAX}) begin
            pw_clamped = POWER_MAX;
        end else begin
            pw_clamped = item.power_watts[11:0];
        end
        inst_pw = stale ? POWER_INVALID : pw_clamped;
        cad_out = stale ? BYTE_NA : item.cadence_rpm;
        acc_sum = stale ? acc_reg : acc_reg + {4'd0, pw_clamped};
    end

    always_comb begin
        icnt_next       = icnt_reg;
        parity_next     = parity_reg;
        event_next      = event_reg;
        acc_next        = acc_reg;
        bg_idx_next     = bg_idx_reg;
        pending_next    = pending_reg;
        cmd_page_next   = cmd_page_reg;
        cmd_status_next = cmd_status_reg;
        cmd_data_next   = cmd_data_reg;
        result          = '0;
        has_result      = 1'b0;

        if (item.kind == KIND_SLOT) begin
            has_result         = 1'b1;
            result.result_kind = KIND_SLOT;
            icnt_next          = bg_slot ? 8'd0 : icnt_inc;
            parity_next        = ~parity_reg;
            if (pending_reg) begin
                pending_next   = 1'b0;
                result.payload = {cmd_data_reg, 6'd0, cmd_status_reg, BYTE_NA,
                                  cmd_page_reg, PAGE_STATUS};
            end else if (bg_slot) begin
                bg_idx_next = (bg_idx_reg >= BG_LAST) ? BG_CAPS : bg_idx_reg + 2'd1;
                if (bg_idx_reg == BG_CAPS) begin
                    result.payload = {CAPS_ALL, {6{BYTE_NA}}, PAGE_CAPS};
                end else if (bg_idx_reg == BG_MANUF) begin
                    result.payload = {cfg.model_number, cfg.manufacturer_id,
                                      cfg.hw_revision, BYTE_NA, BYTE_NA, PAGE_MANUF};
                end else begin
                    result.payload = {cfg.device_serial, cfg.sw_revision,
                                      BYTE_NA, BYTE_NA, PAGE_PRODUCT};
                end
            end else if (parity_next) begin
                result.payload = {fe_state, 4'd0, {4{BYTE_NA}}, el_byte,
                                  EQUIP_TRAINER, PAGE_GENERAL};
            end else begin
                event_next     = event_inc;
                acc_next       = acc_sum;
                result.payload = {fe_state, 4'd0, 4'd0, inst_pw[11:8], inst_pw[7:0],
                                  acc_sum, cad_out, event_inc, PAGE_TRAINER};
            end
        end else begin
            case (rx_page)
                PAGE_POWER: begin
                    has_result            = 1'b1;
                    result.control_mode   = MODE_POWER;
                    result.target_power_w = item.rx_payload[63:50];
                    cmd_data_next         = {item.rx_payload[63:48], 16'hFFFF};
                end
                PAGE_RESIST: begin
                    has_result            = 1'b1;
                    result.control_mode   = MODE_RESIST;
                    result.resistance_pct = item.rx_payload[63:57];
                    cmd_data_next         = {item.rx_payload[63:56], 24'hFFFFFF};
                end
                PAGE_TRACK: begin
                    has_result           = 1'b1;
                    result.control_mode  = MODE_SIM;
                    result.wind_speed    = item.rx_payload[23:8];
                    result.grade         = item.rx_payload[39:24];
                    result.rolling_coeff = item.rx_payload[47:40];
                    result.wind_coeff    = item.rx_payload[55:48];
                    cmd_data_next        = item.rx_payload[55:24];
                end
                default: begin
                    has_result = 1'b0;
                end
            endcase
            if (has_result) begin
                result.result_kind = KIND_RX;
                cmd_page_next      = rx_page;
                cmd_status_next    = CMD_PASS;
                pending_next       = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            icnt_reg       <= 8'd0;
            parity_reg     <= 1'b0;
            event_reg      <= 8'd0;
            acc_reg        <= 16'd0;
            bg_idx_reg     <= BG_CAPS;
            pending_reg    <= 1'b0;
            cmd_page_reg   <= BYTE_NA;
            cmd_status_reg <= CMD_NOT_SUPPORTED;
            cmd_data_reg   <= 32'hFFFF_FFFF;
        end else if (advance) begin
            icnt_reg       <= icnt_next;
            parity_reg     <= parity_next;
            event_reg      <= event_next;
            acc_reg        <= acc_next;
            bg_idx_reg     <= bg_idx_next;
            pending_reg    <= pending_next;
            cmd_page_reg   <= cmd_page_next;
            cmd_status_reg <= cmd_status_next;
            cmd_data_reg   <= cmd_data_next;
        end
    end

endmodule

[design/fectpe_out_stage.sv]
// ----------------------------------------------------------------------------
// fectpe_out_stage
// Result register: hold a finished result until the downstream side takes
// the transaction, reload in the same cycle it drains.
// ----------------------------------------------------------------------------
module fectpe_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  fectpe_pkg::res_item_t result,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output fectpe_pkg::res_item_t held
);
    import fectpe_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    res_item_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = data_reg;

endmodule

[design/fec_trainer_page_engine.sv]
// ----------------------------------------------------------------------------
// fec_trainer_page_engine
// Trainer broadcast page rotation and control page decoder.
//
//   Channel   Dir   Handshake           Contents
//   s_*       in    s_tvalid/s_tready   slot event or received control page
//   m_*       out   m_tvalid/m_tready   broadcast page or decoded command
//   cfg_*     in    cfg_we              register index and write data
//
// One transaction per cycle is taken unless a stalled result holds the
// input register; results pass from the input to the result register.
// The page is built in one pass including one 31x32 constant multiply for
// the elapsed-time byte.
// Reset is synchronous: counters clear, command status returns to
// not supported, registers take their defaults. A stalled result holds the
// input side only once the input register is also occupied.
// ----------------------------------------------------------------------------
module fec_trainer_page_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    // kind
    input  logic                                s_tuser,
    // rx_payload, power_watts, cadence_rpm, data_valid, data_age_ms,
    // elapsed_ms, zero fill
    input  logic [fectpe_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // result_kind
    output logic                                m_tuser,
    // payload, control_mode, target_power_w, resistance_pct, wind_speed,
    // grade, rolling_coeff, wind_coeff, zero fill
    output logic [fectpe_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [fectpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fectpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import fectpe_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    in_item_t  item_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    logic      has_result;
    logic      out_free;
    logic      advance;
    res_item_t result;
    res_item_t held;

    fectpe_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign item_next.kind        = s_tuser;
    assign item_next.rx_payload  = s_tdata[63:0];
    assign item_next.power_watts = s_tdata[79:64];
    assign item_next.cadence_rpm = s_tdata[87:80];
    assign item_next.data_valid  = s_tdata[88];
    assign item_next.data_age_ms = s_tdata[120:89];
    assign item_next.elapsed_ms  = s_tdata[152:121];

    assign advance       = in_valid_reg && (out_free || !has_result);
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    fectpe_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (item_reg),
        .advance    (advance),
        .has_result (has_result),
        .result     (result)
    );

    fectpe_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && has_result),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .held     (held)
    );

    assign m_tuser = held.result_kind;
    assign m_tdata = {1'b0, held.wind_coeff, held.rolling_coeff, held.grade,
                      held.wind_speed, held.resistance_pct, held.target_power_w,
                      held.control_mode, held.payload};

endmodule
